// ----- design/quadtree_region_painter_top_defines.svh -----
// Assertion macros for the quadtree region painter.
// Used by the top level; expects clk and rst in scope where expanded.
`ifndef QUADTREE_REGION_PAINTER_TOP_DEFINES_SVH
`define QUADTREE_REGION_PAINTER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset
`define QRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define QRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/qrp_pkg.sv -----
// Shared types and codes for the quadtree region painter.
// No dependencies; imported by every module of the block.
package qrp_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_PAINT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 8'd128;

  // Input item
  typedef struct packed {
    logic [1:0]  op;
    logic        color;
    logic [2:0]  levels;
    logic [13:0] path;
    logic [6:0]  row;
    logic [6:0]  col;
  } qrp_in_t;

  // Result item
  typedef struct packed {
    logic pixel;
    logic out_of_range;
  } qrp_out_t;

  // Sweep status towards the controller
  typedef struct packed {
    logic busy;
    logic last;
  } qrp_sweep_stat_t;

endpackage

// ----- design/qrp_region.sv -----
// Region set-up: decodes a quadtree path against the configured square.
// Depends on qrp_pkg. Holds the registered rectangle for the sweep.
module qrp_region #(
  parameter int SIDE = 128,
  parameter int AW   = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          clear,
  input  logic          color_in,
  input  logic [2:0]    levels,
  input  logic [13:0]   path,
  input  logic [7:0]    image_rows,
  input  logic [7:0]    image_cols,
  output logic [AW-1:0] ystart,
  output logic [AW-1:0] xstart,
  output logic [AW-1:0] ylast,
  output logic [AW-1:0] xlast,
  output logic          color,
  output logic          skip
);
  import qrp_pkg::*;

  localparam int EW = (AW > 9 ? AW : 9) + 1;
  localparam logic [EW-1:0] SIDE_E = EW'(SIDE);
  localparam logic [AW-1:0] LAST_IDX = AW'(SIDE - 1);

  logic [7:0]    dim_max;
  logic [3:0]    lk;
  logic [3:0]    sh;
  logic [6:0]    lmask;
  logic [6:0]    rbits;
  logic [6:0]    cbits;
  logic          deep;
  logic          off;
  logic [EW-1:0] k;
  logic [EW-1:0] r0;
  logic [EW-1:0] c0;
  logic [EW-1:0] rend;
  logic [EW-1:0] cend;
  logic [EW-1:0] yl;
  logic [EW-1:0] xl;

  // Square side exponent: smallest lk with 2^lk >= max(rows, cols)
  always_comb begin
    dim_max = (image_rows > image_cols) ? image_rows : image_cols;
    lk = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if ((9'd1 << i) < {1'b0, dim_max}) lk = 4'(i + 1);
    end
  end

  // Row digits are the odd path bits, column digits the even ones
  always_comb begin
    for (int j = 0; j < 7; j++) begin
      rbits[j] = path[2*j+1];
      cbits[j] = path[2*j];
    end
    lmask = 7'((8'd1 << levels) - 8'd1);
    deep  = {1'b0, levels} > lk;
    sh    = lk - {1'b0, levels};
    k     = EW'(1) << sh;
    r0    = EW'(rbits & lmask) << sh;
    c0    = EW'(cbits & lmask) << sh;
    off   = (r0 >= SIDE_E) || (c0 >= SIDE_E);
    rend  = r0 + k;
    cend  = c0 + k;
    yl    = ((rend > SIDE_E) ? SIDE_E : rend) - EW'(1);
    xl    = ((cend > SIDE_E) ? SIDE_E : cend) - EW'(1);
  end

  // Reset loads the whole-bitmap clear so the memory is swept after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ystart <= '0;
      xstart <= '0;
      ylast  <= LAST_IDX;
      xlast  <= LAST_IDX;
      color  <= 1'b0;
      skip   <= 1'b0;
    end else if (load) begin
      if (clear) begin
        ystart <= '0;
        xstart <= '0;
        ylast  <= LAST_IDX;
        xlast  <= LAST_IDX;
        color  <= 1'b0;
        skip   <= 1'b0;
      end else begin
        ystart <= r0[AW-1:0];
        xstart <= c0[AW-1:0];
        ylast  <= yl[AW-1:0];
        xlast  <= xl[AW-1:0];
        color  <= color_in;
        skip   <= deep || off;
      end
    end
  end

endmodule

// ----- design/qrp_sweep.sv -----
// Pixel sweep: walks a rectangle row by row, one bitmap write per cycle.
// Depends on qrp_pkg for the status struct.
module qrp_sweep #(
  parameter int AW = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [AW-1:0]           ystart,
  input  logic [AW-1:0]           xstart,
  input  logic [AW-1:0]           ylast,
  input  logic [AW-1:0]           xlast,
  input  logic                    color,
  output logic                    we,
  output logic [2*AW-1:0]         waddr,
  output logic                    wdata,
  output qrp_pkg::qrp_sweep_stat_t stat
);
  import qrp_pkg::*;

  logic          busy;
  logic [AW-1:0] y;
  logic [AW-1:0] x;
  logic [AW-1:0] y_end;
  logic [AW-1:0] x_end;
  logic [AW-1:0] x_first;
  logic          fill;
  logic          x_wrap;
  logic          done;

  assign x_wrap = (x == x_end);
  assign done   = busy && x_wrap && (y == y_end);

  // Counters and captured bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      y       <= ystart;
      x       <= xstart;
      y_end   <= ylast;
      x_end   <= xlast;
      x_first <= xstart;
      fill    <= color;
    end else if (busy) begin
      if (x_wrap) begin
        x <= x_first;
        y <= y + AW'(1);
      end else begin
        x <= x + AW'(1);
      end
    end
  end

  assign we        = busy;
  assign waddr     = {y, x};
  assign wdata     = fill;
  assign stat.busy = busy;
  assign stat.last = done;

endmodule

// ----- design/qrp_bitmap_mem.sv -----
// Bitmap store: one bit per pixel, one write and one registered read port.
// No dependencies beyond qrp_pkg.
module qrp_bitmap_mem #(
  parameter int AW = 7
) (
  input  logic            clk,
  input  logic            we,
  input  logic [2*AW-1:0] waddr,
  input  logic            wdata,
  input  logic            re,
  input  logic [2*AW-1:0] raddr,
  output logic            rdata
);
  import qrp_pkg::*;

  localparam int DEPTH = 1 << (2 * AW);

  logic mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- design/quadtree_region_painter_top.sv -----
// Quadtree region painter, top level.
// Uses qrp_pkg, qrp_region, qrp_sweep, qrp_bitmap_mem and the assertion macros.
//
// Usage:
//  Input items arrive on item/item_valid/item_stall; an item is taken when
//  item_valid is high and item_stall low. Only a read gives a result item on
//  result/result_valid/result_stall, held until result_stall is low.
//  Configuration: cfg_write_en with cfg_index (0 rows, 1 columns) and
//  cfg_data, to be written only while the block is idle; not enforced by the block.
//  Timing, set by the bitmap memory's one write port and registered read:
//   read  - the result register is loaded once no held result is stalled;
//           the next item is taken after it has been loaded.
//   paint - a set-up state, then one write per pixel of the clipped
//           square (up to SIDE*SIDE), then the next item; a path deeper
//           than the square or a square off the bitmap skips the sweep.
//   clear - the set-up state and a sweep of the whole bitmap with zeros.
//  Reset: registers return to 128, then the bitmap is zeroed by the same
//  sweep as a clear, during which item_stall is high.
//  A stalled result blocks only a following read; paints and clears go on.
`include "quadtree_region_painter_top_defines.svh"

module quadtree_region_painter_top #(
  parameter int SIDE = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  qrp_pkg::qrp_in_t                    item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output qrp_pkg::qrp_out_t                   result,
  input  logic                                cfg_write_en,
  input  logic [qrp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qrp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import qrp_pkg::*;

  localparam int AW = $clog2(SIDE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [7:0]       image_rows;
  logic [7:0]       image_cols;
  logic             accept;
  logic             is_paint;
  logic             is_clear;
  logic             is_read;
  logic             oor;
  logic             oor_now;
  logic             out_load;
  logic [AW-1:0]    ystart;
  logic [AW-1:0]    xstart;
  logic [AW-1:0]    ylast;
  logic [AW-1:0]    xlast;
  logic             reg_color;
  logic             skip;
  logic             sweep_start;
  qrp_sweep_stat_t  sweep_stat;
  logic             mem_we;
  logic [2*AW-1:0]  mem_waddr;
  logic             mem_wdata;
  logic             mem_rdata;

  // Input decode
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign is_paint   = accept && (item.op == OP_PAINT);
  assign is_clear   = accept && (item.op == OP_CLEAR);
  assign is_read    = accept && (item.op == OP_READ);

  // Read range check against the registers and the bitmap size
  assign oor_now = ({1'b0, item.row} >= image_rows) || ({1'b0, item.col} >= image_cols) ||
                   (32'(item.row) >= 32'(SIDE)) || (32'(item.col) >= 32'(SIDE));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= CFG_DIM_RESET;
      image_cols <= CFG_DIM_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_ROWS: image_rows <= cfg_data;
        CFG_COLS: image_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Controller
  assign sweep_start = (state == ST_PREP) && !skip;
  assign out_load    = (state == ST_READ) && (!result_valid || !result_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (is_paint || is_clear) state_next = ST_PREP;
        else if (is_read) state_next = ST_READ;
      end
      ST_PREP: state_next = skip ? ST_IDLE : ST_RUN;
      ST_RUN: begin
        if (sweep_stat.last) state_next = ST_IDLE;
      end
      ST_READ: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_PREP;
    else state <= state_next;
  end

  // Range flag of the pending read
  always_ff @(posedge clk) begin
    if (is_read) oor <= oor_now;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.pixel        <= oor ? 1'b0 : mem_rdata;
      result.out_of_range <= oor;
    end
  end

  qrp_region #(
    .SIDE (SIDE),
    .AW   (AW)
  ) u_region (
    .clk        (clk),
    .rst        (rst),
    .load       (is_paint || is_clear),
    .clear      (is_clear),
    .color_in   (item.color),
    .levels     (item.levels),
    .path       (item.path),
    .image_rows (image_rows),
    .image_cols (image_cols),
    .ystart     (ystart),
    .xstart     (xstart),
    .ylast      (ylast),
    .xlast      (xlast),
    .color      (reg_color),
    .skip       (skip)
  );

  qrp_sweep #(
    .AW (AW)
  ) u_sweep (
    .clk    (clk),
    .rst    (rst),
    .start  (sweep_start),
    .ystart (ystart),
    .xstart (xstart),
    .ylast  (ylast),
    .xlast  (xlast),
    .color  (reg_color),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .stat   (sweep_stat)
  );

  qrp_bitmap_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (is_read),
    .raddr ({AW'(item.row), AW'(item.col)}),
    .rdata (mem_rdata)
  );

  // Checks
  `QRP_ASSERT_IMP(a_write_in_run, mem_we, state == ST_RUN, "bitmap written outside a sweep")
  `QRP_ASSERT_IMP(a_result_from_read, $rose(result_valid), $past(state) == ST_READ, "result without read")
  `QRP_ASSERT_IMP(a_oor_pixel_zero, result_valid && result.out_of_range, !result.pixel, "pixel set out of range")
  `QRP_ASSERT_NEXT(a_last_ends_sweep, sweep_stat.last, !sweep_stat.busy && state == ST_IDLE, "sweep did not end")

endmodule

// ----- tb/qrp_bitmap_checker.sv -----
// Bitmap checker for the quadtree region painter: watches the item, result
// and register channels, predicts read results and compares them in order.
// Depends on qrp_pkg for the item types, op codes and register indexes.
module qrp_bitmap_checker #(
  parameter int SIDE = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_stall,
  input  qrp_pkg::qrp_in_t               item,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  qrp_pkg::qrp_out_t              result,
  input  logic                           cfg_write_en,
  input  logic [qrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qrp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  import qrp_pkg::*;

  // Shadow copy of the bitmap and the size registers
  bit [SIDE*SIDE-1:0] canvas;
  int                 img_rows;
  int                 img_cols;
  qrp_out_t           read_q[$];

  // Fill the square that a quadrant path leads to, clipped to the bitmap
  task automatic paint_region(input bit color, input int depth, input int path);
    int span;
    int top_row;
    int left_col;
    int digit;
    span     = 1;
    top_row  = 0;
    left_col = 0;
    while (span < ((img_rows > img_cols) ? img_rows : img_cols)) span = span << 1;
    for (int i = 0; i < depth; i++) begin
      digit = (path >> (2 * (depth - 1 - i))) & 3;
      span  = span >> 1;
      if (digit & 1) left_col += span;
      if (digit & 2) top_row  += span;
    end
    // span of zero means the path went deeper than the square
    for (int y = top_row; y < top_row + span && y < SIDE; y++)
      for (int x = left_col; x < left_col + span && x < SIDE; x++)
        canvas[y*SIDE + x] = color;
  endtask

  // Expected result of a read item
  function automatic qrp_out_t pixel_at(input int row, input int col);
    qrp_out_t res;
    if (row >= img_rows || col >= img_cols || row >= SIDE || col >= SIDE) begin
      res.pixel        = 1'b0;
      res.out_of_range = 1'b1;
    end else begin
      res.pixel        = canvas[row*SIDE + col];
      res.out_of_range = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    qrp_out_t want;
    if (rst) begin
      canvas   = '0;
      img_rows = int'(CFG_DIM_RESET);
      img_cols = int'(CFG_DIM_RESET);
      read_q.delete();
      errors   = 0;
      pending  = 0;
    end else begin
      // register writes
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_ROWS: img_rows = int'(cfg_data);
          CFG_COLS: img_cols = int'(cfg_data);
          default: ;
        endcase
      end
      // result items against the oldest outstanding read
      if (result_valid && !result_stall) begin
        if (read_q.size() == 0) begin
          $error("result item with no read outstanding: pixel %0d, out_of_range %0d",
                 result.pixel, result.out_of_range);
          errors++;
        end else begin
          want = read_q.pop_front();
          if (result.pixel !== want.pixel) begin
            $error("pixel: expected %0d, actual %0d", want.pixel, result.pixel);
            errors++;
          end
          if (result.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0d, actual %0d",
                   want.out_of_range, result.out_of_range);
            errors++;
          end
        end
      end
      // accepted input items update the shadow state
      if (item_valid && !item_stall) begin
        case (item.op)
          OP_PAINT: paint_region(item.color, int'(item.levels), int'(item.path));
          OP_READ:  read_q.push_back(pixel_at(int'(item.row), int'(item.col)));
          OP_CLEAR: canvas = '0;
          default: ;
        endcase
      end
      pending = read_q.size();
    end
  end

endmodule

// ----- tb/quadtree_region_painter_top_tb.sv -----
// Testbench top for the quadtree region painter: clock, reset, item and
// register stimulus, result back-pressure and the verdict.
// Depends on qrp_pkg, quadtree_region_painter_top and qrp_bitmap_checker.
module quadtree_region_painter_top_tb;
  import qrp_pkg::*;

  localparam int SIDE = 128;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  qrp_in_t               item;
  logic                  result_valid;
  logic                  result_stall;
  qrp_out_t              result;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;

  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int cur_rows  = 128;
  int cur_cols  = 128;

  // Sizes for the random phases, extremes among them
  int phase_rows [8] = '{128, 1, 255, 7, 128, 0, 33, 128};
  int phase_cols [8] = '{128, 1, 3, 100, 64, 9, 33, 128};

  quadtree_region_painter_top #(.SIDE(SIDE)) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  qrp_bitmap_checker #(.SIDE(SIDE)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result back-pressure, with a long hold-off on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offer one item and wait for it to be taken; a random gap may follow
  task automatic offer(input qrp_in_t it);
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    end
  endtask

  task automatic send(input logic [1:0] op, input int color, input int depth,
                      input int path, input int row, input int col);
    qrp_in_t it;
    it.op     = op;
    it.color  = 1'(color);
    it.levels = 3'(depth);
    it.path   = 14'(path);
    it.row    = 7'(row);
    it.col    = 7'(col);
    offer(it);
  endtask

  // Pause until every read has answered and any paint or clear has finished
  task automatic settle();
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SIDE*SIDE + 16) @(negedge clk);
  endtask

  task automatic set_dims(input int r, input int c);
    settle();
    cur_rows     = r;
    cur_cols     = c;
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_ROWS;
    cfg_data     <= 8'(r);
    @(negedge clk);
    cfg_index    <= CFG_COLS;
    cfg_data     <= 8'(c);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Stimulus
  initial begin
    qrp_in_t it;
    int      done_items;
    int      roll;
    int      lim_r;
    int      lim_c;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait out the clearing pass, then full-size square
    set_dims(128, 128);
    send(OP_READ, 0, 0, 0, 0, 0);
    send(OP_PAINT, 1, 0, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 127, 127);
    send(OP_PAINT, 0, 7, 'h3FFF, 0, 0);
    send(OP_READ, 0, 0, 0, 127, 127);
    send(OP_READ, 0, 0, 0, 126, 127);
    send(OP_PAINT, 0, 1, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 63, 63);
    send(OP_READ, 0, 0, 0, 63, 64);
    send(OP_PAINT, 0, 7, 'h1555, 0, 0);
    send(OP_PAINT, 0, 7, 'h2AAA, 0, 0);
    send(OP_READ, 0, 0, 0, 0, 127);
    send(OP_READ, 0, 0, 0, 127, 0);
    // unused op is ignored
    send(OP_UNUSED, 1, 7, 'h3FFF, 127, 127);
    send(OP_CLEAR, 0, 0, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 64, 64);

    // tiny square: a path deeper than the square paints nothing
    set_dims(2, 2);
    send(OP_PAINT, 1, 1, 3, 0, 0);
    send(OP_PAINT, 1, 2, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 1, 1);
    send(OP_READ, 0, 0, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 2, 0);

    // zero sizes: square of one, every read out of range
    set_dims(0, 0);
    send(OP_PAINT, 1, 0, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 0, 0);

    // square larger than the bitmap: off-bitmap quadrant dropped
    set_dims(200, 1);
    send(OP_PAINT, 1, 1, 3, 0, 0);
    send(OP_PAINT, 1, 1, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 5, 0);
    send(OP_READ, 0, 0, 0, 5, 1);

    // random phases, each with its own sizes and idling pattern
    for (int p = 0; p < 8; p++) begin
      set_dims(phase_rows[p], phase_cols[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      lim_r = (cur_rows > SIDE) ? SIDE : cur_rows;
      lim_c = (cur_cols > SIDE) ? SIDE : cur_cols;

      // long result hold-off while reads keep coming, so the input backs up
      if (p == 4) begin
        hold_req = 1'b1;
        repeat (16) send(OP_READ, 0, 0, 0, $urandom_range(0, 127), $urandom_range(0, 127));
        settle();
      end

      done_items = 0;
      while (done_items < 7) begin
        it.color  = 1'($urandom);
        it.levels = 3'($urandom);
        it.path   = 14'($urandom);
        it.row    = 7'($urandom);
        it.col    = 7'($urandom);
        roll      = $urandom_range(0, 99);
        if (roll < 3) begin
          it.op = OP_UNUSED;
        end else if (roll < 5) begin
          it.op = OP_CLEAR;
        end else if (roll < 50) begin
          it.op = OP_PAINT;
          // keep most paints small so big squares stay rare
          if (cur_rows <= 16 && cur_cols <= 16)
            it.levels = 3'($urandom_range(0, 7));
          else if ($urandom_range(0, 19) == 0)
            it.levels = 3'($urandom_range(0, 1));
          else
            it.levels = 3'($urandom_range(2, 7));
        end else begin
          it.op = OP_READ;
          if ($urandom_range(0, 1) && lim_r > 0) it.row = 7'($urandom_range(0, lim_r - 1));
          if ($urandom_range(0, 1) && lim_c > 0) it.col = 7'($urandom_range(0, lim_c - 1));
        end
        offer(it);
        if (it.op != OP_UNUSED) done_items++;
      end
    end

    // drain and verdict
    idle_pct  = 0;
    stall_pct = 0;
    settle();
    if (errors == 0 && pending == 0) begin
      $display("quadtree_region_painter_top: match");
    end else begin
      $display("quadtree_region_painter_top: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000000;
    $display("quadtree_region_painter_top: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/qrp_pkg.sv
design/qrp_region.sv
design/qrp_sweep.sv
design/qrp_bitmap_mem.sv
design/quadtree_region_painter_top.sv
tb/qrp_bitmap_checker.sv
tb/quadtree_region_painter_top_tb.sv
